FILE: hdl/rmf_pkg.sv
// Shared types and constants for the running median filter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 9;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // What one cell shows its neighbours in the sorted row.
    typedef struct packed {
        sample_t value;      // stored sample, zero while the cell is empty
        logic    keep_above; // stored sample ranks at or above the incoming one
        logic    past_rem;   // stored sample is at or below the evicted one
    } cell_link_t;

endpackage

FILE: hdl/rmf_if.sv
// Valid/ready channel interfaces for the running median filter.
// Depends on rmf_pkg for the sample type.
`timescale 1ns / 1ps

interface rmf_sample_if;
    logic             valid;
    logic             ready;
    rmf_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmf_median_if;
    logic             valid;
    logic             ready;
    rmf_pkg::sample_t median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

FILE: hdl/rmf_cell.sv
// One cell of the sorted sample row: holds one sample and reorders with its neighbours.
// Depends on rmf_pkg for the sample and link types.
`timescale 1ns / 1ps

module rmf_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  rmf_pkg::sample_t    new_sample,
    input  rmf_pkg::sample_t    old_sample,
    input  rmf_pkg::cell_link_t prev_link,
    input  rmf_pkg::cell_link_t next_link,
    output rmf_pkg::cell_link_t link
);

    rmf_pkg::sample_t value_reg;
    rmf_pkg::sample_t value_next;
    logic             keep_above;
    logic             past_rem;
    logic             first_rem;
    rmf_pkg::sample_t from_above;

    assign keep_above = (value_reg >= new_sample);
    assign past_rem   = (value_reg <= old_sample);
    // The topmost cell holding the evicted value is the one that leaves the row.
    assign first_rem  = past_rem && !prev_link.past_rem;
    // Where the row opens downwards, the new sample lands in the gap below the cell above.
    assign from_above = prev_link.keep_above ? new_sample : prev_link.value;

    always_comb
    begin
        case ({keep_above, past_rem})
            2'b10:   value_next = value_reg;
            2'b00:   value_next = from_above;
            2'b11:   value_next = next_link.keep_above ? next_link.value : new_sample;
            2'b01:   value_next = first_rem ? from_above : value_reg;
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift_en)
        begin
            value_reg <= value_next;
        end
    end

    assign link = '{value: value_reg, keep_above: keep_above, past_rem: past_rem};

endmodule

FILE: hdl/rmf_delay_line.sv
// Arrival-order shift line that yields the sample about to leave the window.
// Depends on rmf_pkg for the sample type.
`timescale 1ns / 1ps

module rmf_delay_line #(
    parameter int DEPTH = rmf_pkg::WINDOW_DEFAULT
) (
    input  logic             clk,
    input  logic             shift_en,
    input  rmf_pkg::sample_t din,
    output rmf_pkg::sample_t dout
);

    rmf_pkg::sample_t tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: hdl/running_median_filter.sv
// Running median filter: top level with the sorted cell row, eviction line and output register.
// Depends on rmf_pkg, rmf_if, rmf_cell and rmf_delay_line.
`timescale 1ns / 1ps

// The filter takes one 16-bit unsigned sample per word and returns one word per sample: the
// median of the last WINDOW samples (the lower median when the count held is even), counting
// only the samples seen since reset while the window fills. A sample of zero is taken as one,
// so a result is never zero. The samples are kept in descending order in a row of WINDOW cells;
// each accepted word evicts the oldest sample, once the window is full, and inserts the new one
// across the whole row at the edge that accepts it, every cell deciding from its two neighbours
// alone. The result is held pending and is picked from the row into the output register when
// that register is free or is being emptied. The block sustains one word per cycle while the
// output is taken. The sample that leaves the window comes from a WINDOW-deep shift line in
// arrival order. No clearing pass is needed after reset.

module running_median_filter #(
    parameter int WINDOW = rmf_pkg::WINDOW_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    rmf_sample_if.sink          sample_ch,
    rmf_median_if.source        median_ch
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);

    // Handshake and bookkeeping registers.
    logic               pend_reg;
    logic               pend_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    rmf_pkg::sample_t   median_reg;

    logic               accept;
    logic               pend_load;
    logic               full;
    logic [IDX_W-1:0]   med_idx;
    rmf_pkg::sample_t   new_sample;
    rmf_pkg::sample_t   line_out;
    rmf_pkg::sample_t   old_sample;

    rmf_pkg::cell_link_t link     [WINDOW];
    rmf_pkg::sample_t    cell_val [WINDOW];

    // A pending result moves into the output register whenever that register is free or
    // is being emptied; a new word may be taken in the same cycle.
    assign pend_load       = pend_reg && (!out_valid_reg || median_ch.ready);
    assign sample_ch.ready = !pend_reg || pend_load;
    assign accept          = sample_ch.valid && sample_ch.ready;

    // Zero is reserved for empty cells, so a zero sample is raised to one.
    assign new_sample = (sample_ch.sample == '0) ? rmf_pkg::SAMPLE_W'(1) : sample_ch.sample;

    // Until the window is full nothing is evicted: an evicted value of zero makes the first
    // empty cell the one that opens, which appends the sample to the valid part of the row.
    assign full       = (fill_reg == FILL_W'(WINDOW));
    assign old_sample = full ? line_out : '0;

    rmf_delay_line #(
        .DEPTH (WINDOW)
    ) u_line (
        .clk      (clk),
        .shift_en (accept),
        .din      (new_sample),
        .dout     (line_out)
    );

    // The sorted row, largest sample in cell zero. The ends see fixed neighbours: above the
    // first cell everything ranks high and nothing is evicted, below the last cell the
    // opposite holds.
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        rmf_pkg::cell_link_t prev_link;
        rmf_pkg::cell_link_t next_link;

        if (i == 0)
        begin : g_top
            assign prev_link = '{value: '0, keep_above: 1'b1, past_rem: 1'b0};
        end
        else
        begin : g_mid_top
            assign prev_link = link[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_bottom
            assign next_link = '{value: '0, keep_above: 1'b0, past_rem: 1'b1};
        end
        else
        begin : g_mid_bottom
            assign next_link = link[i+1];
        end

        rmf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .new_sample (new_sample),
            .old_sample (old_sample),
            .prev_link  (prev_link),
            .next_link  (next_link),
            .link       (link[i])
        );

        assign cell_val[i] = link[i].value;
    end

    // With k samples held the median sits at index floor(k/2) from the top.
    assign med_idx = IDX_W'(fill_reg >> 1);

    always_comb
    begin
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;

        if (accept && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end

        if (pend_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (median_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (pend_load)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The row and fill count already reflect the pending word when it is loaded.
    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            median_reg <= cell_val[med_idx];
        end
    end

    assign median_ch.valid        = out_valid_reg;
    assign median_ch.median_value = median_reg;

endmodule

FILE: hdl/rmf_checker.sv
// Port-level checks for the running median filter, bound to the top level.
// Depends on rmf_pkg for the sample type and on running_median_filter for the bind.
`timescale 1ns / 1ps

module rmf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input rmf_pkg::sample_t median_value
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // A result word waiting on a stalled output keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value))
        else $error("median word changed while stalled");

    // Zero samples are raised to one, so a result is never zero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> median_value != '0)
        else $error("median word is zero");

    // Input back-pressure only ever comes from a full, stalled output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // An output that turns valid was filled through the pending flag from an accepted word.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 2))
        else $error("result appeared without a matching input word");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (median_ch.valid),
    .out_ready    (median_ch.ready),
    .median_value (median_ch.median_value)
);

FILE: tb/running_median_filter_tb.sv
// Self-checking testbench for the running median filter with its default window.
// Depends on rmf_pkg, rmf_if and running_median_filter from the hdl folder.
`timescale 1ns / 1ps

module running_median_filter_tb;

    localparam int WIN         = rmf_pkg::WINDOW_DEFAULT;
    localparam int LONG_HOLD   = 150;     // cycles of the deliberate receiver hold-off
    localparam int SETTLE      = 8;       // cycles waited after the last result
    localparam int MAX_REPORTS = 10;

    // Idling regime of the two channels. The sender idles lightly while the receiver
    // is sluggish, then the roles swap, and finally neither side idles at all.
    typedef enum logic [1:0] {
        MODE_RX_SLOW,
        MODE_TX_SLOW,
        MODE_NO_IDLE
    } idle_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rmf_sample_if sample_ch ();
    rmf_median_if median_ch ();

    running_median_filter #(
        .WINDOW (WIN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .median_ch (median_ch)
    );

    always #1 clk = ~clk;

    idle_mode_t       mode = MODE_RX_SLOW;
    rmf_pkg::sample_t sample_backlog[$];    // words waiting to be offered to the filter
    rmf_pkg::sample_t median_due[$];        // medians predicted for accepted words, oldest first
    int unsigned      fail_count = 0;
    int unsigned      hold_left;
    logic             hold_done;

    // Our own copy of the window: a ring of the samples held, the slot that the
    // next word overwrites, and how many slots hold a valid sample so far.
    rmf_pkg::sample_t ring[WIN] = '{default: '0};
    int unsigned      next_slot = 0;
    int unsigned      held      = 0;

    // Percentage of cycles in which one side of the handshake idles.
    function automatic int unsigned idle_share(idle_mode_t m, bit sender);
        case (m)
            MODE_RX_SLOW: return sender ? 16 : 85;
            MODE_TX_SLOW: return sender ? 85 : 16;
            default:      return 0;
        endcase
    endfunction

    // Stores one sample in the window and returns the value that the filter must
    // report for it. A zero is stored as one. Only the slots written since reset
    // are ranked; they are sorted in descending order and the entry at rank
    // (held + 2) / 2, counted from one at the largest, is taken, which gives the
    // lower median whenever the count held is even.
    function automatic rmf_pkg::sample_t store_and_rank(rmf_pkg::sample_t s);
        rmf_pkg::sample_t ranked[WIN];
        rmf_pkg::sample_t v;
        int unsigned      j;

        if (s == '0)
            s = rmf_pkg::sample_t'(1);
        ring[next_slot] = s;
        next_slot = (next_slot + 1 == WIN) ? 0 : next_slot + 1;
        if (held < WIN)
            held++;

        for (int i = 0; i < WIN; i++)
            ranked[i] = ring[i];
        for (int i = 1; i < held; i++)
        begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] < v)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        return ranked[(held + 2) / 2 - 1];
    endfunction

    // Random sample with a bias towards the awkward corners: many ties and zeros
    // among small values, the extremes of the range, slow drift around the last
    // value, and walking one and walking zero patterns.
    function automatic rmf_pkg::sample_t draw_sample(rmf_pkg::sample_t prev);
        case ($urandom_range(0, 9))
            4, 5:    return rmf_pkg::sample_t'($urandom_range(0, 3));
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return rmf_pkg::sample_t'(1);
                    2:       return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
            end
            7:       return prev + rmf_pkg::sample_t'($urandom_range(0, 4))
                            - rmf_pkg::sample_t'(2);
            8:       return rmf_pkg::sample_t'(1) << $urandom_range(0, rmf_pkg::SAMPLE_W - 1);
            9:       return ~(rmf_pkg::sample_t'(1) << $urandom_range(0, rmf_pkg::SAMPLE_W - 1));
            default: return rmf_pkg::sample_t'($urandom);
        endcase
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic queue_random(input int unsigned count);
        rmf_pkg::sample_t last;

        last = '0;
        for (int unsigned n = 0; n < count; n++)
        begin
            last = draw_sample(last);
            sample_backlog.push_back(last);
        end
    endtask

    // Returns once every queued word has been accepted and every predicted median
    // has come back. Polled on the falling edge so that the backlog and the mode
    // are never touched at the same instant as the clocked processes use them.
    task automatic drain;
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_ch.valid || median_due.size() != 0);
    endtask

    // Sender side. A word stays on the channel until it is taken; after that the
    // next word is offered unless the sender chooses to idle this cycle, in which
    // case the payload carries junk so that the filter must ignore it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= '0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= idle_share(mode, 1'b1))
            begin
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= sample_backlog.pop_front();
            end
            else
            begin
                sample_ch.valid  <= 1'b0;
                sample_ch.sample <= rmf_pkg::sample_t'($urandom);
            end
        end
    end

    // The long hold-off is timed here, on its own. It starts once, as soon as the
    // regime without idling begins, so that the sender keeps offering words while
    // the receiver refuses them; the filter has to fill up and push back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (mode == MODE_NO_IDLE && !hold_done)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver side: ready is withdrawn at random, and throughout the hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            median_ch.ready <= 1'b0;
        else
            median_ch.ready <= (hold_left == 0)
                               && ($urandom_range(0, 99) >= idle_share(mode, 1'b0));
    end

    // Both monitors share one block so that the order in which a result is checked
    // and a new prediction is queued is fixed. The result is checked first: a
    // median can never belong to a word that is accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n && median_ch.valid && median_ch.ready)
        begin
            if (median_due.size() == 0)
                note_failure($sformatf("median %0d arrived with no word outstanding",
                                       median_ch.median_value));
            else if (median_ch.median_value !== median_due[0])
                note_failure($sformatf("median_value expected %0d, got %0d",
                                       median_due.pop_front(), median_ch.median_value));
            else
                void'(median_due.pop_front());
        end
        if (rst_n && sample_ch.valid && sample_ch.ready)
            median_due.push_back(store_and_rank(sample_ch.sample));
    end

    // Stimulus and the final verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. The very first word is a zero, so the first median must
        // be one; the next eight words fill the window from the extremes and from
        // alternating bit patterns, so every count from one to the full window is
        // ranked. Then a run of equal maxima evicts the early words, zeros are mixed
        // with ones to show that both rank the same, and the window turns over again.
        sample_backlog = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000,
                           16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001,
                           16'h0000, 16'h0001, 16'h0000, 16'hFFFE, 16'h0002,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000};
        queue_random(256);
        drain();

        // Every word has come back here, so the sender has paused with nothing left
        // inside the filter before the regime changes.
        mode = MODE_TX_SLOW;
        queue_random(285);
        drain();

        mode = MODE_NO_IDLE;
        queue_random(285);
        drain();

        repeat (SETTLE) @(posedge clk);
        if (median_due.size() != 0)
            note_failure($sformatf("%0d medians never arrived", median_due.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rmf_pkg.sv
hdl/rmf_if.sv
hdl/rmf_cell.sv
hdl/rmf_delay_line.sv
hdl/running_median_filter.sv
hdl/rmf_checker.sv
tb/running_median_filter_tb.sv
